/* rtl/slpq_pkg.sv */
// Shared types and codes for the sorted-list priority queue.
// Operation and status encodings; no dependencies.
package slpq_pkg;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned IdW     = 8;
  localparam int unsigned ScoreInW = 32;

  // Operation codes carried on func_i
  typedef enum logic [FuncW-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_POP    = 2'd2
  } func_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

endpackage

/* rtl/sorted_list_priority_queue.sv */
// Sorted-list priority queue: slot memories plus the list-walk sequencer.
// Depends on slpq_pkg for operation and status codes.
//
// Usage: one input beat (func_i, item_id_i, score_i) gives exactly one output
// beat (status_o, popped_id_o, slots_used_o). Both channels use valid/stall;
// a beat moves when valid is high and stall is low.
// func CLEAR empties the list, INSERT links a new entry in descending score
// order (newer first among equal scores), POP returns the head id.
// Steps from input beat to output valid:
//   clear, unused code, pop on empty, insert while full: result at accept
//   pop: the head read in POP_RD; insert on an empty list: LINK_NEW
//   other inserts: WALK past each entry with a greater score, then LINK_NEW
//   and, unless the new entry becomes the head, LINK_PREV.
// The walk goes over the linked list one entry per
// cycle through the single read port of the slot memories.
// One item is in flight at a time; in_stall_o is high while an item is being
// worked on, and while a result sits in the output register with out_stall_i
// high. The output register holds its beat stable under stall.
// Reset empties the list (head at the end marker, zero slots used); slot
// memories are not cleared, no clearing pass is needed.
module sorted_list_priority_queue #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned SCORE_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [slpq_pkg::FuncW-1:0]           func_i,
  input  logic [slpq_pkg::IdW-1:0]             item_id_i,
  input  logic signed [slpq_pkg::ScoreInW-1:0] score_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [slpq_pkg::StatusW-1:0]         status_o,
  output logic [slpq_pkg::IdW-1:0]             popped_id_o,
  output logic [$clog2(CAPACITY+1)-1:0]        slots_used_o
);
  import slpq_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned PtrW = $clog2(CAPACITY + 1);
  localparam logic [PtrW-1:0] EndMark = PtrW'(CAPACITY);
  localparam int unsigned SW = SCORE_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_WALK,
    ST_LINK_NEW,
    ST_LINK_PREV
  } state_e;

  state_e state_q;

  // list control
  logic [PtrW-1:0] head_q;
  logic [PtrW-1:0] used_q;
  logic [IdxW-1:0] slot_q;
  logic [PtrW-1:0] cur_q;
  logic [PtrW-1:0] prev_q;
  logic [SW-1:0]   new_score_q;

  // output register
  logic                out_valid_q;
  logic [StatusW-1:0]  status_q;
  logic [IdW-1:0]      popped_q;
  logic [PtrW-1:0]     slots_q;

  // slot memories and registered read data
  logic [IdW-1:0]  mem_id    [CAPACITY];
  logic [SW-1:0]   mem_score [CAPACITY];
  logic [PtrW-1:0] mem_next  [CAPACITY];
  logic [IdW-1:0]  rd_id_q;
  logic [SW-1:0]   rd_score_q;
  logic [PtrW-1:0] rd_next_q;

  logic            in_acc;
  logic            out_free;
  logic            list_full;
  logic            data_we;
  logic            next_we;
  logic [IdxW-1:0] next_waddr;
  logic [PtrW-1:0] next_wdata;
  logic [IdxW-1:0] rd_addr;
  logic [SW-1:0]   score_in;
  logic            walk_on;
  logic            res_done;

  // score taken as SCORE_WIDTH bits two's complement; a wider score is zero-extended
  if (SW <= ScoreInW) begin : g_score_trunc
    assign score_in = score_i[SW-1:0];
  end else begin : g_score_ext
    assign score_in = {{(SW - ScoreInW){1'b0}}, score_i};
  end

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign list_full  = (used_q == EndMark);

  // walk continues while the stored score beats the new one
  assign walk_on = ($signed(rd_score_q) > $signed(new_score_q));

  // memory port control and result completion
  always_comb begin
    data_we    = in_acc && (func_e'(func_i) == FUNC_INSERT) && !list_full;
    next_we    = 1'b0;
    next_waddr = slot_q;
    next_wdata = cur_q;
    rd_addr    = head_q[IdxW-1:0];
    res_done   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        // ops with no list work finish at accept
        res_done = in_acc &&
                   !((func_e'(func_i) == FUNC_INSERT) && !list_full) &&
                   !((func_e'(func_i) == FUNC_POP) && (head_q != EndMark));
      end
      ST_POP_RD:    res_done = 1'b1;
      ST_WALK:      rd_addr = rd_next_q[IdxW-1:0];
      ST_LINK_NEW: begin
        next_we  = 1'b1;
        res_done = (prev_q == EndMark);
      end
      ST_LINK_PREV: begin
        next_we    = 1'b1;
        next_waddr = prev_q[IdxW-1:0];
        next_wdata = PtrW'(slot_q);
        res_done   = 1'b1;
      end
      default: ;
    endcase
  end

  // slot memories: the new slot is never on the list while it is walked,
  // so a read never meets a write to the same entry
  always_ff @(posedge clk_i) begin
    if (data_we) begin
      mem_id[used_q[IdxW-1:0]]    <= item_id_i;
      mem_score[used_q[IdxW-1:0]] <= score_in;
    end
    if (next_we) begin
      mem_next[next_waddr] <= next_wdata;
    end
    rd_id_q    <= mem_id[rd_addr];
    rd_score_q <= mem_score[rd_addr];
    rd_next_q  <= mem_next[rd_addr];
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= EndMark;
      used_q      <= '0;
      slot_q      <= '0;
      cur_q       <= EndMark;
      prev_q      <= EndMark;
      new_score_q <= '0;
      out_valid_q <= 1'b0;
      status_q    <= STATUS_OK;
      popped_q    <= '0;
      slots_q     <= '0;
    end else begin
      // a finished item loads the register; otherwise a taken beat empties it
      if (res_done) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            popped_q <= '0;
            unique case (func_e'(func_i))
              FUNC_CLEAR: begin
                head_q   <= EndMark;
                used_q   <= '0;
                status_q <= STATUS_OK;
                slots_q  <= '0;
              end
              FUNC_INSERT: begin
                slots_q <= used_q;
                if (list_full) begin
                  status_q <= STATUS_FULL;
                end else begin
                  status_q    <= STATUS_OK;
                  slot_q      <= used_q[IdxW-1:0];
                  new_score_q <= score_in;
                  cur_q       <= head_q;
                  prev_q      <= EndMark;
                  state_q     <= (head_q == EndMark) ? ST_LINK_NEW : ST_WALK;
                end
              end
              FUNC_POP: begin
                slots_q <= used_q;
                if (head_q == EndMark) begin
                  status_q <= STATUS_EMPTY;
                end else begin
                  status_q <= STATUS_OK;
                  state_q  <= ST_POP_RD;
                end
              end
              default: begin
                status_q <= STATUS_OK;
                slots_q  <= used_q;
              end
            endcase
          end
        end
        ST_POP_RD: begin
          popped_q <= rd_id_q;
          head_q   <= rd_next_q;
          state_q  <= ST_IDLE;
        end
        ST_WALK: begin
          if (walk_on) begin
            prev_q <= cur_q;
            cur_q  <= rd_next_q;
            if (rd_next_q == EndMark) begin
              state_q <= ST_LINK_NEW;
            end
          end else begin
            state_q <= ST_LINK_NEW;
          end
        end
        ST_LINK_NEW: begin
          if (prev_q == EndMark) begin
            head_q  <= PtrW'(slot_q);
            used_q  <= used_q + 1'b1;
            slots_q <= used_q + 1'b1;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_LINK_PREV;
          end
        end
        ST_LINK_PREV: begin
          used_q  <= used_q + 1'b1;
          slots_q <= used_q + 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign popped_id_o  = popped_q;
  assign slots_used_o = slots_q;

  // checks
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= EndMark) else $error("slot count past capacity");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= EndMark) else $error("head pointer past end marker");

  a_walk_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (cur_q != EndMark))
    else $error("walk on end marker");

  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK || state_q == ST_POP_RD) |-> !in_acc)
    else $error("input taken while busy");

  a_insert_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LINK_PREV) |=> (used_q == $past(used_q) + 1'b1))
    else $error("insert did not consume a slot");

endmodule
